// ===== design/adaptive_frame_skip_governor_defines.svh =====
// Assertion macros for the frame-skip governor checker.
// No dependencies; the user must have clk and rst_n in scope.
`ifndef ADAPTIVE_FRAME_SKIP_GOVERNOR_DEFINES_SVH
`define ADAPTIVE_FRAME_SKIP_GOVERNOR_DEFINES_SVH

// same-cycle implication, masked during reset
`define AFSG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afsg check failed");

// next-cycle implication, masked during reset
`define AFSG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afsg check failed");

// property that must hold in the cycle after reset is seen
`define AFSG_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("afsg check failed");

`endif

// ===== design/afsg_pkg.sv =====
// Shared types, constants and control structs for the frame-skip governor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package afsg_pkg;

  // default tuning parameters
  localparam int REPORT_PERIOD_DEF = 5;
  localparam int MAX_SKIP_DEF      = 12;

  // fixed arithmetic constants
  localparam int BLANK_USEC    = 16667;
  localparam int BUDGET_SHIFT  = 3;     // cost * 8
  localparam int DIV_STEPS     = 32;    // one quotient bit per cycle
  localparam int CNT_W         = 5;

  // configuration register indexes
  localparam logic [1:0] REG_ENABLED      = 2'd0;
  localparam logic [1:0] REG_DYNAMIC_MODE = 2'd1;
  localparam logic [1:0] REG_FIXED_SKIP   = 2'd2;

  typedef struct packed {
    logic [31:0] now_seconds;
    logic [31:0] window_usec;
    logic [15:0] window_frames;
  } in_item_t;

  typedef struct packed {
    logic        composite_now;
    logic        window_closed;
    logic [7:0]  skip_in_use;
    logic [31:0] cost_per_composite;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic tune_init;
    logic tune_step;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_tune;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/afsg_ctrl.sv =====
// Sequencing state machine for the frame-skip governor.
// Depends on afsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afsg_ctrl import afsg_pkg::*; #(
  parameter int MAX_SKIP = MAX_SKIP_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  localparam int TUNE_STEPS = MAX_SKIP - 1;
  localparam int TUNE_LAST  = (TUNE_STEPS > 0) ? TUNE_STEPS - 1 : 0;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_EVAL = 5'b00100,
    S_TUNE = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // next-state and command decode
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        // clear the retune count even when there are no steps to run
        if (status.need_tune) begin
          cmd.tune_init = 1'b1;
          cnt_nxt       = '0;
        end
        if (status.need_tune && (TUNE_STEPS > 0)) begin
          state_nxt = S_TUNE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_TUNE: begin
        cmd.tune_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TUNE_LAST)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output slot to be free or draining
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output slot occupancy
  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/afsg_datapath.sv =====
// Datapath: config registers, blank counter, bit-serial divider,
// reciprocal report-period test, skip retune loop and the output register.
// Depends on afsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afsg_datapath import afsg_pkg::*; #(
  parameter int REPORT_PERIOD = REPORT_PERIOD_DEF,
  parameter int MAX_SKIP      = MAX_SKIP_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   in_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  output out_item_t       out_data
);

  localparam int ACC_W = $clog2(BLANK_USEC * (MAX_SKIP + 1) + 1);
  localparam int CW    = 32 + BUDGET_SHIFT;
  // now / REPORT_PERIOD = (now * RECIP) >> RSH, exact over 32 bits
  localparam int          RSH   = 32 + $clog2(REPORT_PERIOD);
  localparam logic [32:0] RECIP =
    33'((64'd1 << RSH) / 64'(REPORT_PERIOD) + 64'd1);

  // configuration and persistent state
  logic        enabled_r, dynamic_r;
  logic [7:0]  fixed_skip_r;
  logic [7:0]  blanks_r, blanks_nxt;
  logic [3:0]  tuned_r;
  logic [31:0] last_sec_r;

  // per-item working registers
  logic [31:0] now_r;
  logic [31:0] quo_r;
  logic [15:0] rem_r, frames_r;
  logic [31:0] per_quo_r;
  logic        on_period_r;
  logic        composite_r;
  logic [ACC_W-1:0] acc_r;
  logic [3:0]  q_r;
  out_item_t   out_r;

  logic [7:0]  cur_skip;
  logic [7:0]  blanks_inc;
  logic        comp_hit;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [64:0] per_prod;
  logic [31:0] cost;
  logic        closed;
  logic        need_tune;
  logic [CW-1:0] cost8;
  logic [3:0]  tuned_new;
  logic [7:0]  skip_out;

  assign cur_skip = dynamic_r ? {4'd0, tuned_r} : fixed_skip_r;

  // blank counter, saturating at 255
  assign blanks_inc = (blanks_r == 8'hFF) ? blanks_r : blanks_r + 8'd1;
  assign comp_hit   = (blanks_inc >= cur_skip);
  always_comb begin
    blanks_nxt = blanks_r;
    if (enabled_r) begin
      blanks_nxt = comp_hit ? 8'd0 : blanks_inc;
    end
  end

  // restoring divide step: window_usec / window_frames
  assign rem_sh = {rem_r, quo_r[31]};
  assign rem_ge = (rem_sh >= {1'b0, frames_r});

  // report-period quotient by reciprocal multiply
  assign per_prod = {33'd0, now_r} * {32'd0, RECIP};

  // window close decision, valid once the divide loop has finished
  assign cost      = (frames_r == 16'd0) ? 32'd0 : quo_r;
  assign closed    = enabled_r && (now_r != last_sec_r) && on_period_r;
  assign need_tune = closed && dynamic_r && (cost != 32'd0);
  assign status.need_tune = need_tune;

  // retune: q counts thresholds k*BLANK_USEC that cost*8 reaches
  assign cost8     = {cost, BUDGET_SHIFT'(0)};
  assign tuned_new = need_tune ? q_r + 4'd1 : tuned_r;
  assign skip_out  = dynamic_r ? {4'd0, tuned_new} : fixed_skip_r;

  // control and persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      dynamic_r    <= 1'b0;
      fixed_skip_r <= 8'd1;
      blanks_r     <= 8'd0;
      tuned_r      <= 4'd1;
      last_sec_r   <= 32'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLED:      enabled_r <= cfg_data[0];
          REG_DYNAMIC_MODE: begin
            dynamic_r <= cfg_data[0];
            tuned_r   <= 4'd1;
          end
          REG_FIXED_SKIP:   fixed_skip_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        blanks_r <= blanks_nxt;
      end
      if (cmd.commit && closed) begin
        last_sec_r <= now_r;
        tuned_r    <= tuned_new;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r       <= in_data.now_seconds;
      quo_r       <= in_data.window_usec;
      frames_r    <= in_data.window_frames;
      rem_r       <= '0;
      composite_r <= enabled_r && comp_hit;
    end
    if (cmd.step) begin
      quo_r       <= {quo_r[30:0], rem_ge};
      rem_r       <= rem_ge ? 16'(rem_sh - {1'b0, frames_r}) : rem_sh[15:0];
      // the period quotient settles first and the period test follows from it
      per_quo_r   <= 32'(per_prod >> RSH);
      on_period_r <= (now_r == per_quo_r * 32'(REPORT_PERIOD));
    end
    if (cmd.tune_init) begin
      acc_r <= ACC_W'(BLANK_USEC);
      q_r   <= 4'd0;
    end
    if (cmd.tune_step) begin
      if (cost8 >= CW'(acc_r)) begin
        q_r <= q_r + 4'd1;
      end
      acc_r <= acc_r + ACC_W'(BLANK_USEC);
    end
    if (cmd.commit) begin
      out_r.composite_now      <= composite_r;
      out_r.window_closed      <= closed;
      out_r.skip_in_use        <= skip_out;
      out_r.cost_per_composite <= closed ? cost : 32'd0;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== design/adaptive_frame_skip_governor.sv =====
// Adaptive frame-skip governor, top level.
// Channels: in_ (one item per vertical blank: now_seconds, window_usec,
// window_frames), out_ (one result item per input item: composite_now,
// window_closed, skip_in_use, cost_per_composite), cfg_ (register writes:
// 0 enabled, 1 dynamic_mode, 2 fixed_skip; always ready).
// One item is in work at a time; a new item is taken only once the last
// one's result has been committed. After an item is accepted the restoring
// divider runs, then the window close decision, then, when a dynamic-mode
// window closes with a non-zero cost, the retune loop; the result is then
// committed to the output register. The report-period test is a reciprocal
// multiply done meanwhile, and the retune loop compares cost * 8 against
// one multiple of 16667 a cycle.
// The result sits in an output register, so a stalled receiver holds the
// result in place while the next input item is accepted and worked on; the
// block then waits with that next result until the output register frees.
// Reset (synchronous, active low) clears the config and governor state to defaults,
// empties the output register and returns the sequencer to idle.
// Depends on afsg_pkg, afsg_ctrl, afsg_datapath.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_frame_skip_governor import afsg_pkg::*; #(
  parameter int REPORT_PERIOD = REPORT_PERIOD_DEF,
  parameter int MAX_SKIP      = MAX_SKIP_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  afsg_ctrl #(
    .MAX_SKIP (MAX_SKIP)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  afsg_datapath #(
    .REPORT_PERIOD (REPORT_PERIOD),
    .MAX_SKIP      (MAX_SKIP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/afsg_checker.sv =====
// Port-level checks for the frame-skip governor, bound to the top level.
// Depends on afsg_pkg and adaptive_frame_skip_governor_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "adaptive_frame_skip_governor_defines.svh"

module afsg_checker import afsg_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  logic open_result;

  // result shown with its window still open
  assign open_result = out_valid && !out_data.window_closed;

  // a stalled result holds
  `AFSG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // cost is only reported when a window closes
  `AFSG_ASSERT_IMP(a_cost_closed, open_result, out_data.cost_per_composite == 32'd0)

  // one item at a time: the block is busy right after an accept
  `AFSG_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // reset empties the output register
  `AFSG_ASSERT_RST(a_reset_empty, !out_valid)

endmodule

bind adaptive_frame_skip_governor afsg_checker u_afsg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== sim/adaptive_frame_skip_governor_test.sv =====
// Self-checking testbench for the adaptive frame-skip governor.
// Needs afsg_pkg and the governor RTL; drives blanks and register writes,
// predicts every result item in step and compares it field by field.
`timescale 1ns / 1ps

module adaptive_frame_skip_governor_test;
  import afsg_pkg::*;

  localparam logic [1:0]  REG_SPARE    = 2'd3;   // index with no register behind it
  localparam logic [31:0] WINDOW_SECS  = 32'(REPORT_PERIOD_DEF);
  localparam logic [63:0] COST_SCALE   = 64'd8;
  localparam logic [63:0] BLANK_BUDGET = 64'(BLANK_USEC);
  localparam logic [63:0] SKIP_CEILING = 64'(MAX_SKIP_DEF);
  localparam int          MAX_GAP      = 20;
  localparam int          SETTLE_CYCLES = 60;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // governor mirror: registers and state
  logic        gov_enabled;
  logic        gov_dynamic;
  logic [7:0]  gov_fixed_skip;
  logic [7:0]  blanks_seen;
  logic [3:0]  tuned_skip;
  logic [31:0] last_close_sec;

  out_item_t blank_verdicts[$];
  logic [31:0] clock_sec;

  int fail_count   = 0;
  int blanks_sent  = 0;
  int verdicts_ok  = 0;
  int reg_writes   = 0;
  int composites   = 0;
  int closes       = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_seq  = 0;
  int hold_len  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  adaptive_frame_skip_governor DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // skip currently selected by the mode register
  function automatic logic [7:0] skip_now();
    return gov_dynamic ? {4'd0, tuned_skip} : gov_fixed_skip;
  endfunction

  // one vertical blank through the governor mirror
  function automatic out_item_t govern_blank(input in_item_t b);
    out_item_t   r;
    logic [31:0] cost;
    logic [63:0] wanted;
    r = '0;
    cost = '0;
    if (gov_enabled) begin
      if (blanks_seen < 8'd255) blanks_seen++;
      if (blanks_seen >= skip_now()) begin
        blanks_seen = '0;
        r.composite_now = 1'b1;
      end
      // window closes on each new multiple of the report period
      if (b.now_seconds != last_close_sec && (b.now_seconds % WINDOW_SECS) == 32'd0) begin
        last_close_sec = b.now_seconds;
        r.window_closed = 1'b1;
        cost = (b.window_frames != 16'd0) ? b.window_usec / {16'd0, b.window_frames} : '0;
        if (gov_dynamic && cost != 32'd0) begin
          wanted = ({32'd0, cost} * COST_SCALE) / BLANK_BUDGET + 64'd1;
          if (wanted > SKIP_CEILING) wanted = SKIP_CEILING;
          tuned_skip = wanted[3:0];
        end
      end
    end
    r.skip_in_use = skip_now();
    r.cost_per_composite = cost;
    return r;
  endfunction

  function automatic in_item_t blank(input logic [31:0] now, input logic [31:0] usec,
                                     input logic [15:0] frames);
    in_item_t b;
    b.now_seconds   = now;
    b.window_usec   = usec;
    b.window_frames = frames;
    return b;
  endfunction

  // mostly a steadily advancing clock so windows close regularly
  function automatic in_item_t random_blank();
    int          pick;
    logic [15:0] frames;
    logic [31:0] usec;
    pick = $urandom_range(99);
    if (pick < 70) begin
      if ($urandom_range(3) == 0) clock_sec++;
    end else if (pick < 80) begin
      clock_sec = (clock_sec / WINDOW_SECS + 32'd1) * WINDOW_SECS;
    end else if (pick < 90) begin
      clock_sec = $urandom;
    end else begin
      clock_sec = WINDOW_SECS * $urandom_range(0, 858993459);
    end
    pick = $urandom_range(99);
    if (pick < 10) frames = '0;
    else if (pick < 20) frames = 16'($urandom);
    else frames = 16'($urandom_range(1, 60));
    pick = $urandom_range(99);
    if (pick < 15) usec = $urandom;
    else if (frames == 16'd0) usec = $urandom_range(0, 500000);
    else usec = {16'd0, frames} * $urandom_range(0, 30000) + $urandom_range(0, frames);
    return blank(clock_sec, usec, frames);
  endfunction

  // offer one blank, record its verdict on acceptance, then maybe idle
  task automatic send_blank(input in_item_t b);
    int gap;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    blank_verdicts.push_back(govern_blank(b));
    blanks_sent++;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding verdict
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blank_verdicts.size() != 0) @(posedge clk);
  endtask

  // register write; valid stays high unless this is the last of a burst
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ENABLED: begin
        gov_enabled = val[0];
      end
      REG_DYNAMIC_MODE: begin
        gov_dynamic = val[0];
        tuned_skip  = 4'd1;
      end
      REG_FIXED_SKIP: begin
        gov_fixed_skip = val;
      end
      default: ;
    endcase
    reg_writes++;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] en, input logic [7:0] dyn,
                                input logic [7:0] skip);
    drain_results();
    write_reg(REG_ENABLED, en, 1'b0);
    write_reg(REG_DYNAMIC_MODE, dyn, 1'b0);
    write_reg(REG_FIXED_SKIP, skip, 1'b1);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (blank_verdicts.size() == 0) begin
        $error("result item with no blank outstanding");
        fail_count++;
      end else begin
        want = blank_verdicts.pop_front();
        if (out_data.composite_now !== want.composite_now) begin
          $error("composite_now: expected %0d, got %0d",
                 want.composite_now, out_data.composite_now);
          fail_count++;
        end
        if (out_data.window_closed !== want.window_closed) begin
          $error("window_closed: expected %0d, got %0d",
                 want.window_closed, out_data.window_closed);
          fail_count++;
        end
        if (out_data.skip_in_use !== want.skip_in_use) begin
          $error("skip_in_use: expected %0d, got %0d",
                 want.skip_in_use, out_data.skip_in_use);
          fail_count++;
        end
        if (out_data.cost_per_composite !== want.cost_per_composite) begin
          $error("cost_per_composite: expected %0d, got %0d",
                 want.cost_per_composite, out_data.cost_per_composite);
          fail_count++;
        end
        verdicts_ok++;
        if (want.composite_now) composites++;
        if (want.window_closed) closes++;
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // disabled: nothing composites, nothing changes, skip still shown
  task automatic test_disabled();
    send_blank(blank(32'd5, 32'd1000, 16'd2));
    send_blank(blank(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
  endtask

  // window reports in fixed mode, including second zero and empty windows
  task automatic test_window_report();
    apply_settings(8'd1, 8'd0, 8'd1);
    send_blank(blank(32'd0, 32'd500, 16'd1));
    send_blank(blank(32'd5, 32'd100000, 16'd3));
    send_blank(blank(32'd5, 32'd100000, 16'd3));
    send_blank(blank(32'd10, 32'd7777, 16'd0));
    send_blank(blank(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_blank(blank(32'd20, 32'hFFFF_FFFF, 16'd1));
  endtask

  // dynamic retune: ordinary cost, capped cost, zero cost, mode rewrite
  task automatic test_dynamic_retune();
    apply_settings(8'd1, 8'd1, 8'd1);
    send_blank(blank(32'd21, 32'd0, 16'd0));
    send_blank(blank(32'd25, 32'd20000, 16'd4));
    send_blank(blank(32'd26, 32'd0, 16'd0));
    send_blank(blank(32'd26, 32'd0, 16'd0));
    send_blank(blank(32'd30, 32'hFFFF_FFFF, 16'd1));
    send_blank(blank(32'd35, 32'd12345, 16'd0));
    send_blank(blank(32'd40, 32'd1, 16'd2));
    drain_results();
    write_reg(REG_SPARE, 8'hFF, 1'b0);
    write_reg(REG_DYNAMIC_MODE, 8'd1, 1'b1);
    send_blank(blank(32'd41, 32'd0, 16'd0));
  endtask

  // fixed skip of zero and of its maximum
  task automatic test_skip_extremes();
    apply_settings(8'd1, 8'd0, 8'd0);
    send_blank(blank(32'd42, 32'd0, 16'd0));
    send_blank(blank(32'd43, 32'd0, 16'd0));
    apply_settings(8'd1, 8'd0, 8'd255);
    send_blank(blank(32'd44, 32'd0, 16'd0));
    send_blank(blank(32'd45, 32'd9999, 16'd9));
  endtask

  task automatic run_traffic(input int count, input int idle_pct, input int stall_pct,
                             input bit pause_midway);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      // if asked, the sender waits for every verdict at the midway point before carrying on
      if (pause_midway && i == count / 2) drain_results();
      send_blank(random_blank());
    end
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    apply_settings(8'd1, 8'd1, 8'd3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len = 400;
    hold_seq++;
    for (int i = 0; i < 12; i++) send_blank(random_blank());
  endtask

  task automatic test_random_settings();
    apply_settings(8'd1, 8'd0, 8'd1);
    run_traffic(100, 0, 0, 1'b0);
    apply_settings(8'd1, 8'd1, 8'd7);
    run_traffic(150, 56, 0, 1'b0);
    apply_settings(8'd1, 8'd0, 8'd255);
    run_traffic(270, 0, 56, 1'b0);
    apply_settings({7'($urandom_range(127)), 1'b1}, {7'($urandom_range(127)), 1'b1},
                   8'($urandom));
    run_traffic(120, 21, 21, 1'b1);
    apply_settings({7'($urandom_range(127)), 1'b0}, 8'($urandom), 8'($urandom));
    run_traffic(30, 21, 21, 1'b0);
    apply_settings(8'd1, 8'd0, 8'($urandom_range(2, 20)));
    run_traffic(80, 56, 56, 1'b0);
  endtask

  initial begin
    gov_enabled    = 1'b0;
    gov_dynamic    = 1'b0;
    gov_fixed_skip = 8'd1;
    blanks_seen    = '0;
    tuned_skip     = 4'd1;
    last_close_sec = '0;
    clock_sec      = $urandom_range(0, 1000);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disabled();
    test_window_report();
    test_dynamic_retune();
    test_skip_extremes();
    test_output_backpressure();
    test_random_settings();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (blank_verdicts.size() != 0) begin
      $error("%0d blank verdicts never arrived", blank_verdicts.size());
      fail_count++;
    end
    $display("Covered %0d blanks and %0d register writes across fixed, dynamic and disabled",
             blanks_sent, reg_writes);
    $display("modes: %0d results checked, %0d composites, %0d window closes",
             verdicts_ok, composites, closes);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/afsg_pkg.sv
design/afsg_ctrl.sv
design/afsg_datapath.sv
design/adaptive_frame_skip_governor.sv
design/afsg_checker.sv
sim/adaptive_frame_skip_governor_test.sv
